// ----- rtl/pdc_pkg.sv -----
// pdc_pkg: shared types and constants of the pwm duty capture block
`timescale 1ns / 1ps

package pdc_pkg;

  // item kinds after classification
  typedef enum logic [1:0] {
    K_RISE      = 2'd0,
    K_FALL      = 2'd1,
    K_QUERY     = 2'd2,
    K_QUERY_OOR = 2'd3
  } kind_t;

  // raw operation codes on the input stream
  localparam logic [1:0] OP_RISE  = 2'd0;
  localparam logic [1:0] OP_FALL  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int CAP_W   = 32;
  localparam int TIME_W  = 48;
  localparam int DUTY_W  = 14;
  localparam int TMO_W   = 16;
  localparam int NUM_W   = CAP_W + DUTY_W;   // high * 10000 fits here
  localparam int CNT_W   = $clog2(DUTY_W);
  localparam int THRESH_W = 26;              // (65535 + 1) * 1000 fits here

  localparam logic [DUTY_W-1:0]   DUTY_FULL    = 14'd10000;
  localparam logic [9:0]          US_PER_MS    = 10'd1000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 26'd101000;  // timeout 100 ms

  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    kind_t              kind;
    logic               ch;
    logic [CAP_W-1:0]   cap;
    logic [TIME_W-1:0]  now;
  } cmd_t;

endpackage

// ----- rtl/pdc_front.sv -----
// pdc_front: accepts input items, classifies them and drops the ignored ones
`timescale 1ns / 1ps

module pdc_front #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pdc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]                     s_axis_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output pdc_pkg::cmd_t                  q_cmd
);

  localparam logic [4:0] NUM_CH_V = 5'(NUM_CHANNELS);

  logic ch;
  logic in_range;
  logic keep;

  assign ch       = s_axis_tdata[0];
  assign in_range = 5'(ch) < NUM_CH_V;

  always_comb begin
    q_cmd.ch  = ch;
    q_cmd.cap = s_axis_tdata[pdc_pkg::CAP_W:1];
    q_cmd.now = s_axis_tdata[pdc_pkg::CAP_W+pdc_pkg::TIME_W:pdc_pkg::CAP_W+1];
    q_cmd.kind = pdc_pkg::K_RISE;
    keep = 1'b0;
    unique case (s_axis_tuser)
      pdc_pkg::OP_RISE: begin
        q_cmd.kind = pdc_pkg::K_RISE;
        keep = in_range;
      end
      pdc_pkg::OP_FALL: begin
        q_cmd.kind = pdc_pkg::K_FALL;
        keep = in_range;
      end
      pdc_pkg::OP_QUERY: begin
        q_cmd.kind = in_range ? pdc_pkg::K_QUERY : pdc_pkg::K_QUERY_OOR;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;  // unused code, swallowed
      end
    endcase
  end

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full && keep;

endmodule

// ----- rtl/pdc_fifo.sv -----
// pdc_fifo: short command queue between front and back
`timescale 1ns / 1ps

module pdc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pdc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output pdc_pkg::cmd_t head_cmd,
  output logic          empty
);

  pdc_pkg::cmd_t entries [pdc_pkg::QUEUE_DEPTH];
  logic [pdc_pkg::QPTR_W-1:0] wr_ptr;
  logic [pdc_pkg::QPTR_W-1:0] rd_ptr;
  logic [pdc_pkg::QPTR_W:0]   count;

  assign full     = count == (pdc_pkg::QPTR_W+1)'(pdc_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/pdc_divider.sv -----
// pdc_divider: restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pdc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pdc_pkg::NUM_W-1:0]     numer,
  input  logic [pdc_pkg::CAP_W-1:0]     denom,
  output logic                          done,
  output logic [pdc_pkg::DUTY_W-1:0]    quot
);

  // caller guarantees the quotient fits DUTY_W bits, so the upper
  // numerator bits start out below the divisor
  logic [pdc_pkg::CAP_W-1:0]  rem;
  logic [pdc_pkg::CAP_W-1:0]  den_r;
  logic [pdc_pkg::DUTY_W-1:0] nlo;
  logic [pdc_pkg::CNT_W-1:0]  cnt;
  logic                       busy;
  logic [pdc_pkg::CAP_W:0]    trial;
  logic [pdc_pkg::CAP_W:0]    diff;
  logic                       fits;

  assign trial = {rem, nlo[pdc_pkg::DUTY_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= numer[pdc_pkg::NUM_W-1:pdc_pkg::DUTY_W];
      nlo   <= numer[pdc_pkg::DUTY_W-1:0];
      den_r <= denom;
      quot  <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[pdc_pkg::CAP_W-1:0] : trial[pdc_pkg::CAP_W-1:0];
      nlo  <= {nlo[pdc_pkg::DUTY_W-2:0], 1'b0};
      quot <= {quot[pdc_pkg::DUTY_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pdc_pkg::CNT_W'(pdc_pkg::DUTY_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/pdc_back.sv -----
// pdc_back: per-channel state, command sequencer and result register
`timescale 1ns / 1ps

module pdc_back #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          timeout_wr_en,
  input  logic [pdc_pkg::TMO_W-1:0]     timeout_wr_data,
  input  logic                          q_empty,
  input  pdc_pkg::cmd_t                 q_head,
  output logic                          q_pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pdc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tuser
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_AGE,
    S_REPORT
  } state_t;

  state_t state;

  logic [pdc_pkg::CAP_W-1:0]  rise_time      [NUM_CHANNELS];
  logic [pdc_pkg::CAP_W-1:0]  period_count   [NUM_CHANNELS];
  logic                       rise_seen_flag [NUM_CHANNELS];
  logic [pdc_pkg::DUTY_W-1:0] duty_value     [NUM_CHANNELS];
  logic                       valid_flag     [NUM_CHANNELS];
  logic [pdc_pkg::TIME_W-1:0] last_update_us [NUM_CHANNELS];

  logic [pdc_pkg::THRESH_W-1:0] expire_thresh;

  pdc_pkg::cmd_t              cmd_r;
  logic [pdc_pkg::CAP_W-1:0]  high_r;
  logic [pdc_pkg::CAP_W-1:0]  period_r;
  logic [pdc_pkg::NUM_W-1:0]  product_r;
  logic [pdc_pkg::TIME_W-1:0] age_r;
  logic                       age_borrow_r;
  logic                       expire_r;

  logic                        out_ch;
  logic [pdc_pkg::DUTY_W-1:0]  out_duty;
  logic                        out_flag;

  logic                        rd_ch;
  logic [CH_IDX_W-1:0]         idx;
  logic [pdc_pkg::CAP_W-1:0]   rd_high;
  logic [pdc_pkg::TIME_W:0]    age_full;
  logic [pdc_pkg::NUM_W-1:0]   product;
  logic                        div_done;
  logic [pdc_pkg::DUTY_W-1:0]  div_quot;
  logic                        report_fire;

  // one read port on the channel state: the queue head while idle, else the
  // command in flight
  assign rd_ch    = (state == S_IDLE) ? q_head.ch : cmd_r.ch;
  assign idx      = CH_IDX_W'(rd_ch);
  assign rd_high  = q_head.cap - rise_time[idx];
  assign age_full = {1'b0, q_head.now} - {1'b0, last_update_us[idx]};
  assign product  = pdc_pkg::NUM_W'(high_r) * pdc_pkg::NUM_W'(pdc_pkg::DUTY_FULL);

  // result register is free, or empties at this edge
  assign report_fire = (state == S_REPORT) && (!m_axis_tvalid || m_axis_tready);

  assign q_pop = (state == S_IDLE) && !q_empty;

  pdc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .numer (product_r),
    .denom (period_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expire_thresh <= pdc_pkg::THRESH_RESET;
    end else if (timeout_wr_en) begin
      // age / 1000 > timeout  is  age >= (timeout + 1) * 1000
      expire_thresh <= pdc_pkg::THRESH_W'(
        ({11'b0, timeout_wr_data} + 27'd1) * {17'b0, pdc_pkg::US_PER_MS});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_time[i]      <= '0;
        period_count[i]   <= '0;
        rise_seen_flag[i] <= 1'b0;
        duty_value[i]     <= '0;
        valid_flag[i]     <= 1'b0;
        last_update_us[i] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready && !report_fire) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r <= q_head;
            unique case (q_head.kind)
              pdc_pkg::K_RISE: begin
                if (rise_seen_flag[idx]) begin
                  period_count[idx] <= rd_high;
                end
                rise_time[idx]      <= q_head.cap;
                rise_seen_flag[idx] <= 1'b1;
              end
              pdc_pkg::K_FALL: begin
                if (rise_seen_flag[idx] && period_count[idx] != '0) begin
                  high_r   <= rd_high;
                  period_r <= period_count[idx];
                  state    <= S_MUL;
                end
              end
              pdc_pkg::K_QUERY: begin
                age_r        <= age_full[pdc_pkg::TIME_W-1:0];
                age_borrow_r <= age_full[pdc_pkg::TIME_W];
                state        <= S_AGE;
              end
              pdc_pkg::K_QUERY_OOR: begin
                expire_r <= 1'b0;
                state    <= S_REPORT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MUL: begin
          if (high_r >= period_r) begin
            // ratio at or above one: clamp to full scale
            duty_value[idx]     <= pdc_pkg::DUTY_FULL;
            valid_flag[idx]     <= 1'b1;
            last_update_us[idx] <= cmd_r.now;
            state               <= S_IDLE;
          end else begin
            product_r <= product;
            state     <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            duty_value[idx]     <= div_quot;
            valid_flag[idx]     <= 1'b1;
            last_update_us[idx] <= cmd_r.now;
            state               <= S_IDLE;
          end
        end
        S_AGE: begin
          expire_r <= valid_flag[idx] && !age_borrow_r &&
                      (age_r >= pdc_pkg::TIME_W'(expire_thresh));
          state    <= S_REPORT;
        end
        S_REPORT: begin
          if (report_fire) begin
            m_axis_tvalid <= 1'b1;
            out_ch        <= cmd_r.ch;
            if (cmd_r.kind == pdc_pkg::K_QUERY_OOR) begin
              out_duty <= '0;
              out_flag <= 1'b0;
            end else if (expire_r) begin
              valid_flag[idx]     <= 1'b0;
              duty_value[idx]     <= '0;
              rise_seen_flag[idx] <= 1'b0;
              out_duty            <= '0;
              out_flag            <= 1'b0;
            end else begin
              out_duty <= duty_value[idx];
              out_flag <= valid_flag[idx];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, out_duty, out_ch};
  assign m_axis_tuser = out_flag;

endmodule

// ----- rtl/pwm_duty_capture.sv -----
// pwm_duty_capture: top level of the per-channel pwm duty meter
`timescale 1ns / 1ps

// channel     dir   tdata (lsb first)                           tuser
// s_axis      in    channel[0], capture_value[32:1],            operation[1:0]
//                   now_us[80:33], zero pad to 88
// m_axis      out   result_channel[0], duty_hundredths[14:1],   duty_valid[0]
//                   zero pad to 16
// timeout_wr  in    timeout_ms[15:0] written when timeout_wr_en is high
//
// flow: the front takes an item in the cycle it arrives while the two-entry
// queue has room; the back does a rising or ignored falling edge in S_IDLE,
// a clamped one via S_MUL, one that divides via S_MUL, S_DIV_GO and S_DIV
// (14 quotient bits, one per cycle in the shared divider), a query via S_AGE
// and S_REPORT (out of range: S_REPORT); unused codes never reach the back
// reset: synchronous rst clears all channel state, the queue and the result
// register's tvalid, and sets timeout_ms back to 100
// stalls: a result waiting in the output register holds the next query in its
// report step; items behind it collect in the queue until s_axis_tready drops

module pwm_duty_capture #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  // timeout_ms register
  input  logic        timeout_wr_en,
  input  logic [15:0] timeout_wr_data,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // channel, capture_value, now_us, pad
  input  logic [1:0]  s_axis_tuser,   // operation
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // result_channel, duty_hundredths, pad
  output logic        m_axis_tuser    // duty_valid
);

  // classified command between front and queue
  logic          q_push;
  pdc_pkg::cmd_t q_in;
  logic          q_full;
  // queue head toward the back
  logic          q_pop;
  pdc_pkg::cmd_t q_head;
  logic          q_empty;

  // front: decode operation, range-check channel, drop ignored items
  pdc_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in)
  );

  // short queue so the front keeps accepting while the back divides
  pdc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (q_head),
    .empty    (q_empty)
  );

  // back: channel state, duty divide, expiry, result register
  pdc_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .timeout_wr_en   (timeout_wr_en),
    .timeout_wr_data (timeout_wr_data),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser)
  );

endmodule

// ----- rtl/pdc_checker.sv -----
// pdc_checker: port-level assertions on the result stream, bound to the top level
`timescale 1ns / 1ps

module pdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[14:1] <= 14'd10000)
    else $error("duty above full scale");

  // an invalid result always reports zero duty
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[14:1] == 14'd0)
    else $error("invalid result with nonzero duty");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result presented right after reset");

endmodule

bind pwm_duty_capture pdc_checker u_pdc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
